// File: rtl/xsfd_pkg.sv
package xsfd_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int COUNT_BITS    = 32;
	localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
	localparam int CMP_BITS      = (COUNT_BITS > 32) ? COUNT_BITS : 32;

	localparam logic [15:0] ETH_BYTES       = 16'd14;
	localparam logic [15:0] IP_MIN_BYTES    = 16'd20;
	localparam logic [15:0] TCP_MIN_BYTES   = 16'd20;
	localparam logic [7:0]  PROTO_TCP       = 8'd6;
	localparam logic [5:0]  XMAS_PATTERN    = 6'h29;
	localparam logic [31:0] THRESHOLD_RESET = 32'd100;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK
	} state_t;

	// one classified frame handed from front to back
	typedef struct packed {
		logic        is_xmas;
		logic [31:0] addr;
	} item_t;

	// one table entry
	typedef struct packed {
		logic                  valid;
		logic                  blocked;
		logic [COUNT_BITS-1:0] count;
		logic [31:0]           addr;
	} slot_t;

	typedef struct packed {
		logic        is_xmas;
		logic [31:0] source_count;
		logic        blocked;
		logic        newly_blocked;
		logic        table_full;
	} result_t;

	localparam int SLOT_BITS = $bits(slot_t);

	// fold the address onto the table index
	function automatic logic [IDX_BITS-1:0] addr_hash(input logic [31:0] a);
		logic [IDX_BITS-1:0] h;
		h = '0;
		for (int i = 0; i < 32; i++) begin
			h[i % IDX_BITS] = h[i % IDX_BITS] ^ a[i];
		end
		return h;
	endfunction

endpackage

// File: rtl/xsfd_ifs.sv
interface xsfd_frame_if;
	logic        valid;
	logic        ready;
	logic [15:0] packet_length;
	logic [3:0]  ip_header_words;
	logic [7:0]  ip_protocol;
	logic [5:0]  tcp_flag_bits;
	logic [31:0] source_address;

	modport source (output valid, packet_length, ip_header_words, ip_protocol,
		tcp_flag_bits, source_address, input ready);
	modport sink (input valid, packet_length, ip_header_words, ip_protocol,
		tcp_flag_bits, source_address, output ready);
endinterface

interface xsfd_verdict_if;
	logic        valid;
	logic        ready;
	logic        is_xmas;
	logic [31:0] source_count;
	logic        blocked;
	logic        newly_blocked;
	logic        table_full;

	modport source (output valid, is_xmas, source_count, blocked, newly_blocked,
		table_full, input ready);
	modport sink (input valid, is_xmas, source_count, blocked, newly_blocked,
		table_full, output ready);
endinterface

interface xsfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: rtl/xmas_scan_flood_detector.sv
// Path: a frame waits in the front queue and its verdict in the output register; an XMAS
// frame also probes the table in S_LOOK, one more probe per hash collision. Throughput:
// one non-XMAS frame per cycle while the receiver takes verdicts; an XMAS frame holds the
// back end in S_LOOK until its probes end, set by the single read port of the source table.
// Reset: asynchronous, active low; threshold returns to 100, then a sweep clears the source
// table. During the sweep the front still takes up to two frames into its queue, but none
// is looked up until the sweep ends (threshold writes are taken throughout).
module xmas_scan_flood_detector
	import xsfd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	xsfd_frame_if.sink     frame,
	xsfd_verdict_if.source verdict,
	xsfd_cfg_if.sink       cfg
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	// Front: classify each header and hold it in a two-entry queue, so the
	// frame side keeps taking transfers while the back end probes the table.
	xsfd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// Back: hashed table with linear probing. Advance the probe until the
	// source matches or an empty slot turns up; drop the source as table full
	// once every slot has been visited. Results sit in an output register.
	xsfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.verdict (verdict),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// a full table is only ever reported for an XMAS frame
	a_full_is_xmas: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.table_full |-> verdict.is_xmas)
		else $error("table_full without is_xmas");

	// a fresh block mark implies the mark is set
	a_new_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.newly_blocked |-> verdict.blocked && !verdict.table_full)
		else $error("newly_blocked without blocked");

	// a frame that is not XMAS carries an all-zero verdict
	a_plain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && !verdict.is_xmas |->
			verdict.source_count == 32'd0 && !verdict.blocked && !verdict.table_full)
		else $error("non-XMAS verdict not zero");

	// a stored source always has a nonzero count
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.is_xmas && !verdict.table_full |->
			verdict.source_count != 32'd0)
		else $error("counted source with zero count");

endmodule

// File: rtl/xsfd_ram.sv
module xsfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/xsfd_front.sv
module xsfd_front
	import xsfd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	xsfd_frame_if.sink   frame,
	output logic         q_valid,
	output item_t        q_item,
	input  logic         q_pop
);

	item_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        push;
	logic        len_ok;
	logic        tcp_ok;
	logic [16:0] tcp_end;
	item_t       item_in;

	// classify the header
	always_comb begin
		tcp_end = 17'(ETH_BYTES) + 17'(TCP_MIN_BYTES) + {11'd0, frame.ip_header_words, 2'b00};
		len_ok  = frame.packet_length >= (ETH_BYTES + IP_MIN_BYTES);
		tcp_ok  = {1'b0, frame.packet_length} >= tcp_end;
		item_in.is_xmas = len_ok && tcp_ok && (frame.ip_protocol == PROTO_TCP)
			&& (frame.tcp_flag_bits == XMAS_PATTERN);
		item_in.addr = frame.source_address;
	end

	assign frame.ready = (fill_q != 2'd2);
	assign push        = frame.valid && frame.ready;
	assign q_valid     = (fill_q != 2'd0);
	assign q_item      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// File: rtl/xsfd_back.sv
module xsfd_back
	import xsfd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	xsfd_cfg_if.sink      cfg,
	xsfd_verdict_if.source verdict,
	input  logic          q_valid,
	input  item_t         q_item,
	output logic          q_pop
);

	state_t                state_q, state_d;
	logic [IDX_BITS-1:0]   clr_q;
	logic [IDX_BITS-1:0]   probe_q, probe_d;
	logic [IDX_BITS-1:0]   tries_q, tries_d;
	logic [31:0]           addr_q;
	logic [31:0]           thr_q;
	logic                  ov_q;
	result_t               res_q, res_d;
	logic                  load;
	logic                  out_free;
	logic                  ram_we;
	logic [IDX_BITS-1:0]   ram_waddr;
	logic [IDX_BITS-1:0]   ram_raddr;
	slot_t                 ram_wdata;
	logic [SLOT_BITS-1:0]  ram_rdata;
	slot_t                 slot;
	logic [COUNT_BITS-1:0] cnt_new;
	logic                  blk_new;
	logic                  hit;

	xsfd_ram #(.WIDTH(SLOT_BITS), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign slot          = slot_t'(ram_rdata);
	assign cfg.ready     = 1'b1;
	assign out_free      = !ov_q || verdict.ready;
	assign verdict.valid = ov_q;
	assign verdict.is_xmas       = res_q.is_xmas;
	assign verdict.source_count  = res_q.source_count;
	assign verdict.blocked       = res_q.blocked;
	assign verdict.newly_blocked = res_q.newly_blocked;
	assign verdict.table_full    = res_q.table_full;

	always_comb begin
		state_d   = state_q;
		probe_d   = probe_q + 1'b1;
		tries_d   = tries_q + 1'b1;
		q_pop     = 1'b0;
		load      = 1'b0;
		res_d     = '0;
		ram_we    = 1'b0;
		ram_waddr = probe_q;
		ram_wdata = '0;
		ram_raddr = probe_q + 1'b1;
		hit       = slot.valid && (slot.addr == addr_q);
		cnt_new   = hit ? ((slot.count == '1) ? slot.count : slot.count + 1'b1)
			: COUNT_BITS'(1);
		blk_new   = (hit && slot.blocked) || (CMP_BITS'(cnt_new) > CMP_BITS'(thr_q));
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				probe_d   = addr_hash(q_item.addr);
				tries_d   = '0;
				ram_raddr = addr_hash(q_item.addr);
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (q_item.is_xmas) begin
						state_d = S_LOOK;
					end else begin
						load = 1'b1;
					end
				end
			end
			S_LOOK: begin
				if (hit || !slot.valid) begin
					ram_we    = 1'b1;
					ram_wdata = '{valid: 1'b1, blocked: blk_new, count: cnt_new, addr: addr_q};
					res_d     = '{is_xmas: 1'b1, source_count: 32'(CMP_BITS'(cnt_new)),
						blocked: blk_new, newly_blocked: blk_new && !(hit && slot.blocked),
						table_full: 1'b0};
					load      = 1'b1;
					state_d   = S_IDLE;
				end else if (tries_q == '1) begin
					res_d   = '{is_xmas: 1'b1, source_count: 32'd0, blocked: 1'b0,
						newly_blocked: 1'b0, table_full: 1'b1};
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
		if (state_q == S_IDLE && q_pop) begin
			addr_q <= q_item.addr;
		end
		probe_q <= probe_d;
		tries_q <= tries_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			thr_q   <= THRESHOLD_RESET;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg.valid) begin
				thr_q <= cfg.data;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (verdict.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

// File: bench/xsfd_scoreboard.sv
`timescale 1ns / 100ps

module xsfd_scoreboard
	import xsfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	xsfd_frame_if   frame,
	xsfd_verdict_if verdict,
	xsfd_cfg_if     cfg,
	output int      errors,
	output int      pending
);

	logic [31:0] threshold;
	logic [31:0] tally[logic [31:0]];
	bit          marked[logic [31:0]];
	int          entries_used;
	result_t     verdicts_due[$];

	// classify one frame and update the per-source state
	function automatic result_t classify_frame(input logic [15:0] len, input logic [3:0] words,
		input logic [7:0] proto, input logic [5:0] flags, input logic [31:0] addr);
		result_t r;
		bit      was;
		r = '0;
		if (len < 16'd34 || proto != PROTO_TCP ||
			{2'd0, len} < 18'd34 + {12'd0, words, 2'b00} || flags != XMAS_PATTERN)
			return r;
		r.is_xmas = 1'b1;
		if (tally.exists(addr)) begin
			if (tally[addr] != '1)
				tally[addr] = tally[addr] + 32'd1;
		end else if (entries_used >= TABLE_ENTRIES) begin
			r.table_full = 1'b1;
			return r;
		end else begin
			entries_used++;
			tally[addr] = 32'd1;
			marked[addr] = 1'b0;
		end
		was = marked[addr];
		if (tally[addr] > threshold)
			marked[addr] = 1'b1;
		r.source_count = tally[addr];
		r.blocked = marked[addr];
		r.newly_blocked = marked[addr] && !was;
		return r;
	endfunction

	assign pending = verdicts_due.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			threshold = THRESHOLD_RESET;
			tally.delete();
			marked.delete();
			entries_used = 0;
			verdicts_due.delete();
			errors = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				threshold = cfg.data;
			if (frame.valid && frame.ready)
				verdicts_due.push_back(classify_frame(frame.packet_length,
					frame.ip_header_words, frame.ip_protocol, frame.tcp_flag_bits,
					frame.source_address));
			if (verdict.valid && verdict.ready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t: verdict with none expected", $time);
					errors++;
				end else begin
					want = verdicts_due.pop_front();
					if (verdict.is_xmas !== want.is_xmas) begin
						$display("%0t: is_xmas exp %0d got %0d", $time, want.is_xmas,
							verdict.is_xmas);
						errors++;
					end
					if (verdict.source_count !== want.source_count) begin
						$display("%0t: source_count exp %0d got %0d", $time,
							want.source_count, verdict.source_count);
						errors++;
					end
					if (verdict.blocked !== want.blocked) begin
						$display("%0t: blocked exp %0d got %0d", $time, want.blocked,
							verdict.blocked);
						errors++;
					end
					if (verdict.newly_blocked !== want.newly_blocked) begin
						$display("%0t: newly_blocked exp %0d got %0d", $time,
							want.newly_blocked, verdict.newly_blocked);
						errors++;
					end
					if (verdict.table_full !== want.table_full) begin
						$display("%0t: table_full exp %0d got %0d", $time, want.table_full,
							verdict.table_full);
						errors++;
					end
				end
			end
		end
	end

endmodule

// File: bench/tb_xmas_scan_flood_detector.sv
`timescale 1ns / 100ps

module tb_xmas_scan_flood_detector;
	import xsfd_pkg::*;

	localparam int IDLE_LIMIT = 6000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   idle_cycles;
	int   burst_left;
	int   stall_period;
	int   stall_duty;
	int   stall_phase;

	// hot sources so that counts climb past the threshold
	logic [31:0] hot_pool[8];

	xsfd_frame_if   frame ();
	xsfd_verdict_if verdict ();
	xsfd_cfg_if     cfg ();

	xmas_scan_flood_detector dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame),
		.verdict(verdict),
		.cfg    (cfg)
	);

	xsfd_scoreboard scoreboard (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame),
		.verdict(verdict),
		.cfg    (cfg),
		.errors (errors),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// receiver: stall on a duty pattern whose period and duty are re-picked at random
	always @(negedge clk) begin
		if (stall_phase % 64 == 0) begin
			stall_period = $urandom_range(2, 9);
			stall_duty = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period - 1);
		end
		verdict.ready <= (stall_phase % stall_period) >= stall_duty;
		stall_phase++;
	end

	// watchdog: end the run if nothing transfers for too long
	always @(posedge clk) begin
		if ((frame.valid && frame.ready) || (verdict.valid && verdict.ready) ||
			(cfg.valid && cfg.ready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_xmas_scan_flood_detector: done, errors");
			$finish;
		end
	end

	// send one frame; hold valid across a burst, sometimes open a random gap between bursts
	task automatic send_frame(input logic [15:0] len, input logic [3:0] words,
		input logic [7:0] proto, input logic [5:0] flags, input logic [31:0] addr);
		bit done;
		done = 0;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				frame.valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
		end
		burst_left--;
		frame.valid <= 1'b1;
		frame.packet_length <= len;
		frame.ip_header_words <= words;
		frame.ip_protocol <= proto;
		frame.tcp_flag_bits <= flags;
		frame.source_address <= addr;
		while (!done) begin
			#1;
			done = frame.ready;
			@(posedge clk);
			if (!done)
				@(negedge clk);
		end
	endtask

	// mostly well-formed XMAS frames with random content, the rest noise
	task automatic send_random(input int n);
		logic [15:0] len;
		logic [3:0]  words;
		logic [31:0] addr;
		for (int i = 0; i < n; i++) begin
			words = 4'($urandom_range(0, 15));
			addr = ($urandom_range(0, 2) != 0) ? hot_pool[$urandom_range(0, 7)] : $urandom;
			case ($urandom_range(0, 9))
				0, 1: send_frame(16'($urandom), 4'($urandom), 8'($urandom), 6'($urandom),
					$urandom);
				2: send_frame(16'($urandom_range(34, 65535)), words, PROTO_TCP,
					XMAS_PATTERN ^ (6'd1 << $urandom_range(0, 5)), addr);
				3: begin
					// right at the length edge, either side
					len = 16'd34 + 16'(words) * 16'd4 - 16'($urandom_range(0, 1));
					send_frame(len, words, PROTO_TCP, XMAS_PATTERN, addr);
				end
				default: begin
					len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(94, 65535)) :
						16'($urandom_range(94, 1600));
					send_frame(len, words, PROTO_TCP, XMAS_PATTERN, addr);
				end
			endcase
		end
	endtask

	task automatic write_threshold(input logic [31:0] value);
		bit done;
		done = 0;
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		while (!done) begin
			#1;
			done = cfg.ready;
			@(posedge clk);
			@(negedge clk);
		end
		cfg.valid <= 1'b0;
	endtask

	// drop valid and wait until every verdict is back
	task automatic drain();
		@(negedge clk);
		frame.valid <= 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		frame.valid = 1'b0;
		frame.packet_length = '0;
		frame.ip_header_words = '0;
		frame.ip_protocol = '0;
		frame.tcp_flag_bits = '0;
		frame.source_address = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		verdict.ready = 1'b0;
		stall_phase = 0;
		stall_period = 1;
		stall_duty = 0;
		burst_left = 0;
		idle_cycles = 0;
		foreach (hot_pool[i])
			hot_pool[i] = $urandom;
		hot_pool[0] = 32'h0;
		hot_pool[1] = 32'hFFFF_FFFF;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: length and header-length edges, protocols, flag patterns
		send_frame(16'd0, 4'd5, PROTO_TCP, XMAS_PATTERN, 32'h0);
		send_frame(16'd33, 4'd0, PROTO_TCP, XMAS_PATTERN, 32'h0);
		send_frame(16'd34, 4'd0, PROTO_TCP, XMAS_PATTERN, 32'h0);
		send_frame(16'd37, 4'd1, PROTO_TCP, XMAS_PATTERN, 32'h0);
		send_frame(16'd38, 4'd1, PROTO_TCP, XMAS_PATTERN, 32'hFFFF_FFFF);
		send_frame(16'd93, 4'd15, PROTO_TCP, XMAS_PATTERN, 32'hFFFF_FFFF);
		send_frame(16'd94, 4'd15, PROTO_TCP, XMAS_PATTERN, 32'hFFFF_FFFF);
		send_frame(16'hFFFF, 4'd15, PROTO_TCP, XMAS_PATTERN, 32'hFFFF_FFFF);
		send_frame(16'd54, 4'd5, 8'd0, XMAS_PATTERN, 32'h0);
		send_frame(16'd54, 4'd5, 8'hFF, XMAS_PATTERN, 32'h0);
		send_frame(16'd54, 4'd5, 8'd17, XMAS_PATTERN, 32'h0);
		send_frame(16'd54, 4'd5, PROTO_TCP, 6'h00, 32'h0);
		send_frame(16'd54, 4'd5, PROTO_TCP, 6'h3F, 32'h0);
		send_frame(16'd54, 4'd5, PROTO_TCP, 6'h39, 32'h0);
		send_frame(16'd54, 4'd5, PROTO_TCP, 6'h2B, 32'h0);
		send_frame(16'd54, 4'd5, PROTO_TCP, 6'h2D, 32'h0);
		send_frame(16'd54, 4'd5, PROTO_TCP, 6'h28, 32'h0);
		send_frame(16'd54, 4'd5, PROTO_TCP, XMAS_PATTERN, 32'h1234_5678);
		send_frame(16'd54, 4'd5, PROTO_TCP, XMAS_PATTERN, 32'h1234_5678);
		send_random(200);
		drain();

		// every XMAS frame blocks at once
		write_threshold(32'd0);
		send_frame(16'd54, 4'd5, PROTO_TCP, XMAS_PATTERN, 32'hA5A5_0001);
		send_random(120);
		drain();

		// nothing new ever blocks
		write_threshold(32'hFFFF_FFFF);
		send_random(100);
		drain();

		write_threshold(32'd3);
		send_random(200);
		drain();

		// a run of fresh sources, then new and known sources mixed
		write_threshold(32'd1);
		for (int i = 0; i < 80; i++)
			send_frame(16'd54, 4'd5, PROTO_TCP, XMAS_PATTERN, 32'h5A00_0000 + i);
		for (int i = 0; i < 40; i++)
			send_frame(16'd54, 4'd5, PROTO_TCP, XMAS_PATTERN,
				($urandom_range(0, 1) != 0) ? 32'h6B00_0000 + i : hot_pool[$urandom_range(0, 7)]);
		drain();

		if (errors == 0)
			$display("tb_xmas_scan_flood_detector: done, clean");
		else
			$display("tb_xmas_scan_flood_detector: done, errors");
		$finish;
	end

endmodule
